// File: src/assert_macros.svh
// Assertion macros for the level table encoder RTL.
// No dependencies; included by slte_ctrl, which carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form with explicit clock and active-low reset.
`define SLTE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form for modules using the standard clk_i / rst_ni names.
`define SLTE_ASSERT_STD(lbl, prop, msg) \
  `SLTE_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: src/slte_pkg.sv
// Shared types and constants for the sorted level table encoder.
// No dependencies; compiled before every other file of the block.
package slte_pkg;

  localparam int unsigned LEVEL_W         = 32;
  localparam int unsigned CODE_W          = 9;
  localparam int unsigned COUNT_W         = 9;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned MODE_W          = 2;
  localparam int unsigned DEF_TABLE_DEPTH = 256;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_DONE
  } state_e;

  // Ring control from the sequencer to the cell chain.
  typedef struct packed {
    logic               shift;
    logic [LEVEL_W-1:0] feed;
  } ring_ctl_t;

endpackage

// File: src/slte_in_if.sv
// Input channel of the level table encoder: valid/ready plus item fields.
// Depends on slte_pkg for field widths.
interface slte_in_if import slte_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [LEVEL_W-1:0] value;
  logic                      is_missing;
  logic [IDX_W-1:0]          index;

  modport source (output valid, mode, value, is_missing, index, input ready);
  modport sink   (input valid, mode, value, is_missing, index, output ready);
endinterface

// File: src/slte_out_if.sv
// Result channel of the level table encoder: valid/ready plus result fields.
// Depends on slte_pkg for field widths.
interface slte_out_if import slte_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CODE_W-1:0]         code;
  logic                      valid_res;
  logic signed [LEVEL_W-1:0] level_value;
  logic [COUNT_W-1:0]        level_count;
  logic                      table_full;

  modport source (output valid, code, valid_res, level_value, level_count, table_full,
                  input ready);
  modport sink   (input valid, code, valid_res, level_value, level_count, table_full,
                  output ready);
endinterface

// File: src/slte_cell.sv
// One storage cell of the level ring: holds a level, takes the neighbour's on shift.
// Depends on slte_pkg.
module slte_cell import slte_pkg::*; (
  input  logic               clk_i,
  input  logic               shift_i,
  input  logic [LEVEL_W-1:0] data_i,
  output logic [LEVEL_W-1:0] data_o
);

  logic [LEVEL_W-1:0] level_q;
  logic [LEVEL_W-1:0] level_d;

  assign level_d = shift_i ? data_i : level_q;

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign data_o = level_q;

endmodule

// File: src/slte_chain.sv
// Ring of level cells; each shift moves every level one cell towards the head.
// Depends on slte_pkg and slte_cell.
module slte_chain import slte_pkg::*; #(
  parameter int unsigned TableDepth = DEF_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  ring_ctl_t          ctl_i,
  output logic [LEVEL_W-1:0] head_o
);

  logic [LEVEL_W-1:0] link [TableDepth];

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    logic [LEVEL_W-1:0] next_in;
    if (i == TableDepth - 1) begin : g_tail
      assign next_in = ctl_i.feed;
    end else begin : g_body
      assign next_in = link[i+1];
    end
    slte_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(ctl_i.shift),
      .data_i (next_in),
      .data_o (link[i])
    );
  end

  assign head_o = link[0];

endmodule

// File: src/slte_ctrl.sv
// Sequencer and head logic: walks the ring, matches, inserts, drives the result.
// Depends on slte_pkg, slte_in_if, slte_out_if and assert_macros.svh.
`include "assert_macros.svh"
module slte_ctrl import slte_pkg::*; #(
  parameter int unsigned TableDepth = DEF_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  slte_in_if.sink            in_i,
  slte_out_if.source         out_o,
  input  logic [LEVEL_W-1:0] head_i,
  output ring_ctl_t          ring_o
);

  localparam int unsigned CW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned TW = $clog2(TableDepth + 1);
  localparam int unsigned XW = (TW > IDX_W) ? TW : IDX_W;
  localparam logic [CW-1:0] LastStep = CW'(TableDepth - 1);
  localparam logic [TW-1:0] FullCount = TW'(TableDepth);

  state_e             state_q, state_d;
  logic [CW-1:0]      step_q, step_d;
  logic [TW-1:0]      total_q, total_d;
  logic               sort_q;
  mode_e              mode_q, mode_d;
  logic [LEVEL_W-1:0] value_q, value_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               found_q, found_d;
  logic [CW-1:0]      fpos_q, fpos_d;
  logic               ins_q, ins_d;
  logic [LEVEL_W-1:0] carry_q, carry_d;
  logic [LEVEL_W-1:0] rd_q, rd_d;

  logic [CODE_W-1:0]  res_code_q, res_code_d;
  logic               res_valid_q, res_valid_d;
  logic [LEVEL_W-1:0] res_lvl_q, res_lvl_d;
  logic               res_full_q, res_full_d;

  logic               out_valid_q, out_valid_d;
  logic [CODE_W-1:0]  out_code_q, out_code_d;
  logic               out_vres_q, out_vres_d;
  logic [LEVEL_W-1:0] out_lvl_q, out_lvl_d;
  logic [COUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic               out_full_q, out_full_d;

  mode_e              in_mode;
  logic               accept, quick, last, in_range, at_end, match, fnd, load_out;
  logic               to_insert, is_full, at_idx, greater;
  logic [CW-1:0]      fpos_now;

  assign in_mode  = mode_e'(in_i.mode);
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept   = in_i.valid && in_i.ready;
  assign is_full  = (total_q == FullCount);

  always_comb begin
    quick = 1'b0;
    unique case (in_mode)
      MODE_CLEAR:  quick = 1'b1;
      MODE_ENCODE: quick = in_i.is_missing;
      MODE_INSERT: quick = in_i.is_missing || (!sort_q && is_full);
      MODE_READ:   quick = (XW'(in_i.index) >= XW'(total_q));
      default:     quick = 1'b1;
    endcase
  end

  assign last     = (step_q == LastStep);
  assign in_range = (TW'(step_q) < total_q);
  assign at_end   = (TW'(step_q) == total_q);
  assign at_idx   = (XW'(step_q) == XW'(idx_q));
  assign match    = in_range && (head_i == value_q);
  assign fnd      = found_q || match;
  assign fpos_now = found_q ? fpos_q : step_q;
  assign greater  = $signed(head_i) > $signed(value_q);
  assign to_insert = (mode_q == MODE_INSERT) && sort_q && !fnd && !is_full;
  assign load_out = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = quick ? ST_DONE : ST_SCAN;
      ST_SCAN:   if (last) state_d = to_insert ? ST_INSERT : ST_DONE;
      ST_INSERT: if (last) state_d = ST_DONE;
      ST_DONE:   if (load_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    step_d      = step_q;
    total_d     = total_q;
    mode_d      = mode_q;
    value_d     = value_q;
    idx_d       = idx_q;
    found_d     = found_q;
    fpos_d      = fpos_q;
    ins_d       = ins_q;
    carry_d     = carry_q;
    rd_d        = rd_q;
    res_code_d  = res_code_q;
    res_valid_d = res_valid_q;
    res_lvl_d   = res_lvl_q;
    res_full_d  = res_full_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_code_d  = out_code_q;
    out_vres_d  = out_vres_q;
    out_lvl_d   = out_lvl_q;
    out_cnt_d   = out_cnt_q;
    out_full_d  = out_full_q;
    ring_o.shift = 1'b0;
    ring_o.feed  = head_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d      = in_mode;
          value_d     = in_i.value;
          idx_d       = in_i.index;
          step_d      = '0;
          found_d     = 1'b0;
          fpos_d      = '0;
          ins_d       = 1'b0;
          res_code_d  = '0;
          res_valid_d = 1'b1;
          res_lvl_d   = '0;
          res_full_d  = 1'b0;
          if (in_mode == MODE_CLEAR) begin
            total_d = '0;
          end else if (in_mode == MODE_READ && quick) begin
            res_valid_d = 1'b0;
          end else if (in_mode == MODE_INSERT && !in_i.is_missing && quick) begin
            res_full_d = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        ring_o.shift = 1'b1;
        if (mode_q == MODE_INSERT && !sort_q && at_end) begin
          ring_o.feed = value_q;
        end
        found_d = fnd;
        fpos_d  = fpos_now;
        if (mode_q == MODE_READ && at_idx) begin
          rd_d = head_i;
        end
        step_d = last ? '0 : step_q + 1'b1;
        if (last) begin
          unique case (mode_q)
            MODE_ENCODE: begin
              res_valid_d = fnd;
              res_code_d  = fnd ? CODE_W'(TW'(fpos_now) + 1'b1) : '0;
            end
            MODE_READ: res_lvl_d = at_idx ? head_i : rd_q;
            MODE_INSERT: begin
              if (!sort_q) begin
                total_d = total_q + 1'b1;
              end else if (!fnd && is_full) begin
                res_full_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INSERT: begin
        ring_o.shift = 1'b1;
        if (in_range) begin
          if (!ins_q && greater) begin
            ring_o.feed = value_q;
            carry_d     = head_i;
            ins_d       = 1'b1;
          end else if (ins_q) begin
            ring_o.feed = carry_q;
            carry_d     = head_i;
          end
        end else if (at_end) begin
          ring_o.feed = ins_q ? carry_q : value_q;
        end
        step_d = last ? '0 : step_q + 1'b1;
        if (last) begin
          total_d = total_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          out_code_d  = res_code_q;
          out_vres_d  = res_valid_q;
          out_lvl_d   = res_lvl_q;
          out_cnt_d   = COUNT_W'(total_q);
          out_full_d  = res_full_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      total_q     <= '0;
      sort_q      <= 1'b1;
      found_q     <= 1'b0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      total_q     <= total_d;
      found_q     <= found_d;
      ins_q       <= ins_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        sort_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    value_q     <= value_d;
    idx_q       <= idx_d;
    fpos_q      <= fpos_d;
    carry_q     <= carry_d;
    rd_q        <= rd_d;
    res_code_q  <= res_code_d;
    res_valid_q <= res_valid_d;
    res_lvl_q   <= res_lvl_d;
    res_full_q  <= res_full_d;
    out_code_q  <= out_code_d;
    out_vres_q  <= out_vres_d;
    out_lvl_q   <= out_lvl_d;
    out_cnt_q   <= out_cnt_d;
    out_full_q  <= out_full_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.code        = out_code_q;
  assign out_o.valid_res   = out_vres_q;
  assign out_o.level_value = out_lvl_q;
  assign out_o.level_count = out_cnt_q;
  assign out_o.table_full  = out_full_q;

  `SLTE_ASSERT_STD(a_total_bound, total_q <= FullCount, "level count beyond table depth")
  `SLTE_ASSERT_STD(a_idle_step, (state_q == ST_IDLE) |-> (step_q == '0), "step not rewound")
  `SLTE_ASSERT_STD(a_insert_grows,
    (state_q == ST_INSERT && last) |=> (total_q == $past(total_q) + 1'b1),
    "insert pass did not add a level")
  `SLTE_ASSERT_STD(a_out_from_done,
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE),
    "result raised outside done state")

endmodule

// File: src/sorted_level_table_encoder_unit.sv
// Sorted level table encoder: a ring of level cells walked by a single head.
// Depends on slte_pkg, slte_in_if, slte_out_if, slte_chain and slte_ctrl.
//
// Usage: items arrive on in_i (mode, value, is_missing, index) and each gives
// exactly one result on out_o (code, valid_res, level_value, level_count,
// table_full); both channels transfer when valid and ready are high.
// cfg_we_i/cfg_wdata_i write sort_levels; the user must do so only while the
// block is idle, as the block itself does not enforce this. Levels live in a
// ring of TableDepth (N) cells; the head sees one level per cycle as the ring
// rotates. Route from input transfer to result, by item kind:
//   clear, missing encode or insert value, given-mode full insert, read out
//   of range: straight to the done stage
//   encode, read, given-mode insert, sorted duplicate or full insert: one walk
//   sorted insert of a new level: search walk, then shifting walk
// One item is in work at a time; a new item is taken as soon as the previous
// one has reached the result stage, even if that result is not yet taken.
// If the receiver stalls with a result still held, a finished item waits in
// the done stage and in_i.ready stays low until the output frees.
// Reset empties the table (count 0), sets sorted mode and drops any result.
module sorted_level_table_encoder_unit import slte_pkg::*; #(
  parameter int unsigned TableDepth = DEF_TABLE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  slte_in_if.sink    in_i,
  slte_out_if.source out_o
);

  ring_ctl_t          ring;
  logic [LEVEL_W-1:0] head;

  slte_chain #(
    .TableDepth(TableDepth)
  ) u_chain (
    .clk_i (clk_i),
    .ctl_i (ring),
    .head_o(head)
  );

  slte_ctrl #(
    .TableDepth(TableDepth)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .head_i     (head),
    .ring_o     (ring)
  );

endmodule

// File: tb/sorted_level_table_encoder_unit_tb.sv
// Self-checking testbench for sorted_level_table_encoder_unit: directed, full-table,
// back-pressure and random traffic checked against an in-bench table predictor.
// Depends on slte_pkg, slte_in_if, slte_out_if and the unit itself.
module sorted_level_table_encoder_unit_tb import slte_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = DEF_TABLE_DEPTH;
  localparam int unsigned LONG_HOLD    = 600;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam longint unsigned CYCLE_LIMIT = 64'd2_000_000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 70;

  typedef struct packed {
    mode_e              mode;
    logic [LEVEL_W-1:0] value;
    logic               missing;
    logic [IDX_W-1:0]   index;
  } level_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic               valid_res;
    logic [LEVEL_W-1:0] level_value;
    logic [COUNT_W-1:0] level_count;
    logic               table_full;
  } level_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  slte_in_if  in_if ();
  slte_out_if out_if ();

  sorted_level_table_encoder_unit #(
    .TableDepth(DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Predicted table contents and settings
  logic [LEVEL_W-1:0] table_levels [DEPTH];
  int unsigned        table_count;
  bit                 sort_enabled;

  level_result_t level_results_due [$];
  level_result_t result_want;

  int unsigned     errors;
  int unsigned     items_sent;
  int unsigned     results_checked;
  int unsigned     mode_seen [4];
  bit              no_gaps;
  bit              hold_req;
  bit              hold_seen;
  int unsigned     hold_left;
  int unsigned     rx_wait;
  int unsigned     rx_draw;
  longint unsigned cycles;

  function automatic int unsigned find_level_pos(logic [LEVEL_W-1:0] v);
    for (int unsigned i = 0; i < table_count; i++) begin
      if (table_levels[i] == v) return i;
    end
    return table_count;
  endfunction

  function automatic level_result_t predict_level_result(level_item_t it);
    level_result_t r;
    int unsigned pos;
    r = '0;
    r.valid_res = 1'b1;
    case (it.mode)
      MODE_INSERT: begin
        // a sorted insert of a level already held changes nothing
        if (!it.missing && !(sort_enabled && find_level_pos(it.value) < table_count)) begin
          if (table_count >= DEPTH) begin
            r.table_full = 1'b1;
          end else if (sort_enabled) begin
            pos = 0;
            while (pos < table_count && $signed(table_levels[pos]) <= $signed(it.value)) pos++;
            for (int unsigned i = table_count; i > pos; i--) table_levels[i] = table_levels[i-1];
            table_levels[pos] = it.value;
            table_count++;
          end else begin
            table_levels[table_count] = it.value;
            table_count++;
          end
        end
      end
      MODE_ENCODE: begin
        if (!it.missing) begin
          pos = find_level_pos(it.value);
          if (pos < table_count) r.code = CODE_W'(pos + 1);
          else r.valid_res = 1'b0;
        end
      end
      MODE_READ: begin
        if (it.index < table_count) r.level_value = table_levels[it.index];
        else r.valid_res = 1'b0;
      end
      default: begin
        table_count = 0;
      end
    endcase
    r.level_count = COUNT_W'(table_count);
    return r;
  endfunction

  function automatic level_item_t random_level_item();
    level_item_t it;
    int unsigned r;
    int unsigned top;
    r = $urandom_range(0, 99);
    if (r < 45) it.mode = MODE_INSERT;
    else if (r < 80) it.mode = MODE_ENCODE;
    else if (r < 98) it.mode = MODE_READ;
    else it.mode = MODE_CLEAR;
    r = $urandom_range(0, 99);
    if (r < 35 && table_count != 0) begin
      it.value = table_levels[$urandom_range(0, table_count - 1)];
    end else if (r < 55) begin
      it.value = LEVEL_W'($urandom_range(0, 16)) - LEVEL_W'(8);
    end else if (r < 65) begin
      case ($urandom_range(0, 3))
        0:       it.value = 32'h8000_0000;
        1:       it.value = 32'h7FFF_FFFF;
        2:       it.value = '0;
        default: it.value = '1;
      endcase
    end else begin
      it.value = $urandom;
    end
    it.missing = ($urandom_range(0, 15) == 0);
    top = (table_count + 1 > 255) ? 255 : table_count + 1;
    if ($urandom_range(0, 4) == 0) it.index = IDX_W'($urandom_range(0, 255));
    else it.index = IDX_W'($urandom_range(0, top));
    return it;
  endfunction

  task automatic send_level_item(input mode_e m, input logic [LEVEL_W-1:0] v,
                                 input logic miss, input logic [IDX_W-1:0] idx);
    level_item_t it;
    int unsigned gap;
    it = '{mode: m, value: v, missing: miss, index: idx};
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.value      <= v;
    in_if.is_missing <= miss;
    in_if.index      <= idx;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    level_results_due.push_back(predict_level_result(it));
    items_sent++;
    mode_seen[m]++;
  endtask

  task automatic drain_level_results();
    in_if.valid <= 1'b0;
    while (level_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_sort_levels(input bit on);
    drain_level_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sort_enabled = on;
  endtask

  task automatic check_level_field(input string name, input logic [LEVEL_W-1:0] want,
                                   input logic [LEVEL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Empty-table lookups, missing values, extremes, duplicates and reads in sorted mode
  task automatic test_sorted_basics();
    send_level_item(MODE_ENCODE, 32'd5, 1'b0, 8'd0);
    send_level_item(MODE_READ, '0, 1'b0, 8'd0);
    send_level_item(MODE_INSERT, $urandom, 1'b1, 8'd0);
    send_level_item(MODE_ENCODE, $urandom, 1'b1, 8'd0);
    send_level_item(MODE_INSERT, 32'd5, 1'b0, 8'd0);
    send_level_item(MODE_INSERT, -32'sd3, 1'b0, 8'd0);
    send_level_item(MODE_INSERT, 32'h7FFF_FFFF, 1'b0, 8'd0);
    send_level_item(MODE_INSERT, 32'h8000_0000, 1'b0, 8'd0);
    send_level_item(MODE_INSERT, 32'd5, 1'b0, 8'd0);
    send_level_item(MODE_INSERT, 32'd0, 1'b0, 8'd0);
    send_level_item(MODE_ENCODE, 32'h8000_0000, 1'b0, 8'd0);
    send_level_item(MODE_ENCODE, 32'h7FFF_FFFF, 1'b0, 8'd0);
    send_level_item(MODE_ENCODE, 32'd42, 1'b0, 8'd0);
    send_level_item(MODE_READ, '0, 1'b0, 8'd4);
    send_level_item(MODE_READ, '0, 1'b0, 8'd5);
    send_level_item(MODE_READ, '0, 1'b0, 8'd255);
    send_level_item(MODE_CLEAR, '1, 1'b0, 8'd0);
    send_level_item(MODE_ENCODE, 32'd5, 1'b0, 8'd0);
  endtask

  // Given-order duplicates, then a sorted insert into an unsorted table
  task automatic test_given_then_sorted();
    write_sort_levels(1'b0);
    send_level_item(MODE_INSERT, 32'd7, 1'b0, 8'd0);
    send_level_item(MODE_INSERT, 32'd7, 1'b0, 8'd0);
    send_level_item(MODE_INSERT, -32'sd2, 1'b0, 8'd0);
    send_level_item(MODE_ENCODE, 32'd7, 1'b0, 8'd0);
    write_sort_levels(1'b1);
    send_level_item(MODE_INSERT, 32'd3, 1'b0, 8'd0);
    send_level_item(MODE_INSERT, -32'sd2, 1'b0, 8'd0);
    send_level_item(MODE_ENCODE, 32'd3, 1'b0, 8'd0);
  endtask

  // Fill in given order, overflow, then overflow and duplicate with sorting on
  task automatic test_full_table();
    logic [LEVEL_W-1:0] v;
    write_sort_levels(1'b0);
    send_level_item(MODE_CLEAR, $urandom, 1'b0, 8'd0);
    for (int unsigned k = 0; k < DEPTH; k++) begin
      if (k % 6 == 5) v = table_levels[$urandom_range(0, table_count - 1)];
      else v = $urandom;
      send_level_item(MODE_INSERT, v, 1'b0, IDX_W'($urandom_range(0, 255)));
    end
    send_level_item(MODE_INSERT, $urandom, 1'b0, 8'd0);
    send_level_item(MODE_INSERT, $urandom, 1'b1, 8'd0);
    send_level_item(MODE_ENCODE, table_levels[DEPTH-1], 1'b0, 8'd0);
    send_level_item(MODE_READ, '0, 1'b0, 8'd255);
    write_sort_levels(1'b1);
    send_level_item(MODE_INSERT, table_levels[$urandom_range(0, DEPTH - 1)], 1'b0, 8'd0);
    do v = $urandom; while (find_level_pos(v) != table_count);
    send_level_item(MODE_INSERT, v, 1'b0, 8'd0);
    send_level_item(MODE_READ, '0, 1'b0, 8'd0);
    send_level_item(MODE_CLEAR, $urandom, 1'b1, 8'd0);
  endtask

  // Long output stall while short items keep coming
  task automatic test_output_backpressure();
    drain_level_results();
    hold_req = ~hold_req;
    no_gaps  = 1'b1;
    for (int unsigned k = 0; k < 24; k++) begin
      case (k % 3)
        0:       send_level_item(MODE_CLEAR, $urandom, 1'b0, 8'd0);
        1:       send_level_item(MODE_INSERT, $urandom, 1'b1, 8'd0);
        default: send_level_item(MODE_READ, $urandom, 1'b0, 8'd200);
      endcase
    end
    no_gaps = 1'b0;
    drain_level_results();
  endtask

  task automatic test_random_phases();
    logic [RANDOM_PHASES-1:0] sort_plan;
    level_item_t it;
    sort_plan = 6'b110101;
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      write_sort_levels(sort_plan[p]);
      no_gaps = (p == 3);
      if (p == 0 || p == 4) send_level_item(MODE_CLEAR, $urandom, 1'b0, 8'd0);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        it = random_level_item();
        send_level_item(it.mode, it.value, it.missing, it.index);
      end
      no_gaps = 1'b0;
    end
  endtask

  // Result side: random stalls per transfer, plus an occasional long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_wait      <= 0;
      hold_left    <= 0;
      hold_seen    <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= (hold_left == 1);
    end else if (out_if.valid && out_if.ready) begin
      rx_draw = no_gaps ? 0 : $urandom_range(0, 7);
      out_if.ready <= (rx_draw == 0);
      rx_wait      <= (rx_draw == 0) ? 0 : rx_draw - 1;
    end else if (!out_if.ready) begin
      if (rx_wait == 0) out_if.ready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (level_results_due.size() == 0) begin
        $display("%0t: result transfer with none expected, actual code %0h count %0h",
                 $time, out_if.code, out_if.level_count);
        errors++;
      end else begin
        result_want = level_results_due.pop_front();
        check_level_field("code", result_want.code, out_if.code);
        check_level_field("valid_res", result_want.valid_res, out_if.valid_res);
        check_level_field("level_value", result_want.level_value, out_if.level_value);
        check_level_field("level_count", result_want.level_count, out_if.level_count);
        check_level_field("table_full", result_want.table_full, out_if.table_full);
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, level_results_due.size());
      $display("sorted_level_table_encoder_unit_tb failed");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_INSERT;
    in_if.value      = '0;
    in_if.is_missing = 1'b0;
    in_if.index      = '0;
    out_if.ready     = 1'b0;
    table_count      = 0;
    sort_enabled     = 1'b1;
    no_gaps          = 1'b0;
    hold_req         = 1'b0;
    cycles           = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_sorted_basics();
    test_given_then_sorted();
    test_full_table();
    test_output_backpressure();
    test_random_phases();

    drain_level_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d items (insert %0d, encode %0d, read %0d, clear %0d), %0d results checked",
             items_sent, mode_seen[MODE_INSERT], mode_seen[MODE_ENCODE],
             mode_seen[MODE_READ], mode_seen[MODE_CLEAR], results_checked);
    $display("Covered both orderings, a full table, a long output stall and %0d random phases",
             RANDOM_PHASES);
    if (errors == 0) begin
      $display("sorted_level_table_encoder_unit_tb passed");
    end else begin
      $display("sorted_level_table_encoder_unit_tb failed");
    end
    $finish;
  end

endmodule
